// File: src/bes_pkg.sv
`default_nettype none

package bes_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_DOT,
    MODE_QUOT,
    MODE_PARE
  } bes_mode_t;

  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  localparam logic [15:0] DEPTH_MAX = 16'hFFFF;
  localparam int          SEL_BITS  = 16;

  // scan state shared between the step logic and the state registers
  typedef struct packed {
    bes_mode_t   mode;
    bes_mode_t   prev_mode;
    logic [7:0]  quote_char;
    logic [7:0]  bracket_char;
    logic [15:0] nest_depth;
    logic [7:0]  last_char;
    logic        finished;
  } bes_state_t;

  function automatic logic is_close(input logic [7:0] c);
    is_close = (c == CH_RPAREN) || (c == CH_RBRACE) || (c == CH_RBRACKET);
  endfunction

  function automatic logic is_open(input logic [7:0] c);
    is_open = (c == CH_LPAREN) || (c == CH_LBRACE) || (c == CH_LBRACKET);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = c inside {8'd32, [8'd9:8'd13], 8'h85, 8'hA0};
  endfunction

  function automatic logic [7:0] opener_of(input logic [7:0] c);
    case (c)
      CH_RPAREN:   opener_of = CH_LPAREN;
      CH_RBRACE:   opener_of = CH_LBRACE;
      CH_RBRACKET: opener_of = CH_LBRACKET;
      default:     opener_of = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: src/bes_char_if.sv
`default_nettype none

interface bes_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       new_scan;
  logic       text_exhausted;

  modport source (output valid, output char_code, output new_scan,
                  output text_exhausted, input ready);
  modport sink (input valid, input char_code, input new_scan,
                input text_exhausted, output ready);
endinterface

`default_nettype wire

// File: src/bes_result_if.sv
`default_nettype none

interface bes_result_if;
  logic        valid;
  logic        ready;
  logic        scan_done;
  logic        select_ok;
  logic [15:0] select_count;

  modport source (output valid, output scan_done, output select_ok,
                  output select_count, input ready);
  modport sink (input valid, input scan_done, input select_ok,
                input select_count, output ready);
endinterface

`default_nettype wire

// File: src/bes_step.sv
`default_nettype none

module bes_step import bes_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  bes_state_t              st,
  input  logic [COUNT_BITS-1:0]   count,
  input  logic [7:0]              char_code,
  input  logic                    new_scan,
  input  logic                    text_exhausted,
  output bes_state_t              st_next,
  output logic [COUNT_BITS-1:0]   count_next,
  output logic                    scan_done,
  output logic                    select_ok,
  output logic [SEL_BITS-1:0]     select_count
);

  bes_state_t            s;
  logic [COUNT_BITS-1:0] cnt;
  logic                  stop;
  logic [15:0]           depth_dec;

  always_comb begin
    s = st;
    cnt = count;
    if (new_scan) begin
      s.mode = MODE_PLAIN;
      s.prev_mode = MODE_PLAIN;
      s.quote_char = '0;
      s.bracket_char = '0;
      s.nest_depth = '0;
      s.last_char = '0;
      s.finished = 1'b0;
      cnt = '0;
    end

    st_next = s;
    count_next = cnt;
    stop = 1'b0;
    scan_done = 1'b0;
    select_ok = 1'b0;
    depth_dec = (s.nest_depth != 16'd0) ? s.nest_depth - 16'd1 : 16'd0;

    if (s.finished) begin
      // idle item, nothing changes
    end else if (text_exhausted) begin
      scan_done = 1'b1;
      select_ok = (s.mode == MODE_PLAIN) && (cnt != '0);
    end else begin
      if (s.mode == MODE_PLAIN && (is_close(char_code) || is_open(char_code))) begin
        stop = 1'b1;
      end else if (s.prev_mode == MODE_QUOT && s.mode != MODE_QUOT &&
                   char_code == CH_BACKSLASH && s.last_char == s.quote_char) begin
        // escaped quote: back inside the string
        st_next.mode = MODE_QUOT;
      end else if (s.mode == MODE_PLAIN || s.mode == MODE_DOT) begin
        if (char_code == CH_DOT || char_code == CH_COLON) begin
          st_next.prev_mode = s.mode;
          st_next.mode = MODE_DOT;
        end else if (char_code == CH_SQUOTE || char_code == CH_DQUOTE) begin
          st_next.quote_char = char_code;
          st_next.prev_mode = s.mode;
          st_next.mode = MODE_QUOT;
        end else if (is_close(char_code)) begin
          st_next.nest_depth = 16'd1;
          st_next.bracket_char = char_code;
          st_next.prev_mode = s.mode;
          st_next.mode = MODE_PARE;
        end else if (is_blank(char_code) || is_open(char_code)) begin
          stop = 1'b1;
        end else if (s.mode == MODE_DOT) begin
          st_next.prev_mode = s.mode;
          st_next.mode = MODE_PLAIN;
        end
      end else if (s.mode == MODE_QUOT) begin
        if (char_code == s.quote_char) begin
          st_next.prev_mode = s.mode;
          st_next.mode = MODE_PLAIN;
        end
      end else begin
        if (char_code == opener_of(s.bracket_char)) begin
          st_next.nest_depth = depth_dec;
          if (depth_dec == 16'd0) begin
            st_next.prev_mode = s.mode;
            st_next.mode = MODE_PLAIN;
          end
        end else if (char_code == s.bracket_char) begin
          if (s.nest_depth != DEPTH_MAX) begin
            st_next.nest_depth = s.nest_depth + 16'd1;
          end
        end
      end

      if (stop) begin
        st_next = s;
        scan_done = 1'b1;
        select_ok = (s.mode == MODE_PLAIN) && (cnt != '0);
      end else begin
        st_next.last_char = char_code;
        count_next = cnt + 1'b1;
        // count limit reached: scan fails
        if (&count_next) begin
          scan_done = 1'b1;
        end
      end
    end

    if (scan_done) begin
      st_next.finished = 1'b1;
    end
    select_count = select_ok ? SEL_BITS'(cnt) : '0;
  end

endmodule

`default_nettype wire

// File: src/backward_expression_selector_core.sv
// path: a char transfer reaches its result transfer through the input
// register, then the result register
// throughput: one character per cycle while result.ready does not stall it
// reset: synchronous active-high rst empties both registers and leaves the
// scan finished, so items are ignored until one arrives with new_scan set
`default_nettype none

module backward_expression_selector_core import bes_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  bes_char_if.sink      chars,
  bes_result_if.source  result
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_new_scan;
  logic       in_exhausted;
  logic       advance;

  bes_state_t            st;
  bes_state_t            st_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;

  logic                res_valid;
  logic                res_done;
  logic                res_ok;
  logic [SEL_BITS-1:0] res_count;
  logic                step_done;
  logic                step_ok;
  logic [SEL_BITS-1:0] step_count;

  assign advance     = in_valid && (!res_valid || result.ready);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char      <= chars.char_code;
      in_new_scan  <= chars.new_scan;
      in_exhausted <= chars.text_exhausted;
    end
  end

  bes_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .st             (st),
    .count          (count),
    .char_code      (in_char),
    .new_scan       (in_new_scan),
    .text_exhausted (in_exhausted),
    .st_next        (st_next),
    .count_next     (count_next),
    .scan_done      (step_done),
    .select_ok      (step_ok),
    .select_count   (step_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode         <= MODE_PLAIN;
      st.prev_mode    <= MODE_PLAIN;
      st.quote_char   <= '0;
      st.bracket_char <= '0;
      st.nest_depth   <= '0;
      st.last_char    <= '0;
      st.finished     <= 1'b1;
      count           <= '0;
    end else if (advance) begin
      st    <= st_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_done  <= step_done;
      res_ok    <= step_ok;
      res_count <= step_count;
    end
  end

  assign result.valid        = res_valid;
  assign result.scan_done    = res_done;
  assign result.select_ok    = res_ok;
  assign result.select_count = res_count;

endmodule

`default_nettype wire
